// ----- rtl/mseg_pkg.sv -----
`default_nettype none

package mseg_pkg;

    localparam int unsigned LEN_W    = 32;
    localparam int unsigned NUM_W    = 64;
    localparam int unsigned OPCODE_W = 3;
    localparam int unsigned FLAG_W   = 8;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [OPCODE_W-1:0] OP_START_AUTO = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_START_EXPL = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_CONTROL    = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_NEXT       = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_ABORT      = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_FRAG = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_FRAG = 2'd1;

    localparam logic [LEN_W-1:0] MIN_FRAG_RESET = 32'd64;
    localparam logic [LEN_W-1:0] MAX_FRAG_RESET = 32'd65536;

    localparam logic [LEN_W-1:0] TIER_SMALL_MAX = 32'd1024;
    localparam logic [LEN_W-1:0] TIER_MID_MAX   = 32'd1048576;
    localparam logic [LEN_W-1:0] TIER_LARGE_MAX = 32'd10485760;
    localparam logic [LEN_W-1:0] TIER_MID_SIZE  = 32'd16384;
    localparam logic [LEN_W-1:0] TIER_LARGE_SIZE = 32'd32768;
    localparam logic [LEN_W-1:0] TIER_HUGE_SIZE = 32'd65536;

    localparam int unsigned DIV_CNT_W = $clog2(LEN_W);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CLAMP,
        S_DIV,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic [NUM_W-1:0]  message_number;
        logic [LEN_W-1:0]  whole_length;
        logic [LEN_W-1:0]  piece_length;
        logic [LEN_W-1:0]  piece_index;
        logic [LEN_W-1:0]  piece_count;
        logic [LEN_W-1:0]  byte_offset;
        logic              final_piece;
        logic              is_control;
        logic [FLAG_W-1:0] flag_byte;
    } t_header;

    typedef struct packed {
        logic             start;
        logic [LEN_W-1:0] dividend;
        logic [LEN_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [LEN_W-1:0] quotient;
        logic [LEN_W-1:0] remainder;
    } t_div_rsp;

endpackage

`default_nettype wire

// ----- rtl/mseg_div.sv -----
`default_nettype none

module mseg_div (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire mseg_pkg::t_div_req i_req,
    output mseg_pkg::t_div_rsp     o_rsp
);
    import mseg_pkg::*;

    logic [LEN_W-1:0]     r_quot;
    logic [LEN_W-1:0]     r_rem;
    logic [LEN_W-1:0]     r_div;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;

    logic [LEN_W:0] w_trial;
    logic [LEN_W:0] w_diff;
    logic           w_fits;

    // one quotient bit per cycle, restoring
    assign w_trial = {r_rem, r_quot[LEN_W-1]};
    assign w_diff  = w_trial - {1'b0, r_div};
    assign w_fits  = (w_trial >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + DIV_CNT_W'(1);
                if (r_cnt == DIV_CNT_W'(LEN_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quot <= i_req.dividend;
            r_rem  <= '0;
            r_div  <= i_req.divisor;
        end else if (r_busy) begin
            r_quot <= {r_quot[LEN_W-2:0], w_fits};
            r_rem  <= w_fits ? w_diff[LEN_W-1:0] : w_trial[LEN_W-1:0];
        end
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.quotient  = r_quot;
    assign o_rsp.remainder = r_rem;

endmodule

`default_nettype wire

// ----- rtl/message_segmentation_header_generator_core.sv -----
`default_nettype none

// Fragment header generator. A start opcode (auto-sized or explicit) picks a
// fragment size, clamps it to the min/max registers and divides the message
// length by it on a bit-serial divider: the first header of a start is
// registered after the clamp state, the divider run, taking the count and the
// emit state (later while the output stalls), and the input stalls meanwhile.
// Next, control and abort words are handled in the idle state without leaving
// it. The output is a single register; the input stalls while a header waits
// and the output side stalls. An empty message consumes a message number and
// produces nothing. Config writes are always ready.
module message_segmentation_header_generator_core (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_valid,
    output logic                                    o_stall,
    input  wire logic [mseg_pkg::OPCODE_W-1:0]      i_opcode,
    input  wire logic [mseg_pkg::LEN_W-1:0]         i_message_bytes,
    input  wire logic [mseg_pkg::LEN_W-1:0]         i_requested_size,
    input  wire logic [mseg_pkg::FLAG_W-1:0]        i_control_bits,
    output logic                                    o_valid,
    input  wire logic                               i_stall,
    output logic [mseg_pkg::NUM_W-1:0]              o_message_number,
    output logic [mseg_pkg::LEN_W-1:0]              o_whole_length,
    output logic [mseg_pkg::LEN_W-1:0]              o_piece_length,
    output logic [mseg_pkg::LEN_W-1:0]              o_piece_index,
    output logic [mseg_pkg::LEN_W-1:0]              o_piece_count,
    output logic [mseg_pkg::LEN_W-1:0]              o_byte_offset,
    output logic                                    o_final_piece,
    output logic                                    o_is_control,
    output logic [mseg_pkg::FLAG_W-1:0]             o_flag_byte,
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [mseg_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [mseg_pkg::LEN_W-1:0]         i_cfg_data
);
    import mseg_pkg::*;

    t_state           r_state,    n_state;
    logic [LEN_W-1:0] r_min_frag;
    logic [LEN_W-1:0] r_max_frag;
    logic [NUM_W-1:0] r_next_num, n_next_num;
    logic [NUM_W-1:0] r_act_num,  n_act_num;
    logic             r_in_prog,  n_in_prog;
    logic [LEN_W-1:0] r_index,    n_index;
    logic [LEN_W-1:0] r_total,    n_total;
    logic [LEN_W-1:0] r_len,      n_len;
    logic [LEN_W-1:0] r_size,     n_size;
    logic [LEN_W-1:0] r_offset,   n_offset;
    logic             r_out_valid, n_out_valid;
    t_header          r_hdr,      n_hdr;

    logic             w_out_free;
    logic             w_accept;
    logic [LEN_W-1:0] w_tier;
    logic [LEN_W-1:0] w_raised;
    logic [LEN_W-1:0] w_capped;
    logic [LEN_W-1:0] w_clamped;
    logic [LEN_W-1:0] w_rest;
    logic [LEN_W-1:0] w_piece;
    logic             w_last;
    logic [LEN_W-1:0] w_count;
    t_div_req         w_div_req;
    t_div_rsp         w_div_rsp;

    mseg_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    assign w_out_free = !r_out_valid || !i_stall;
    assign o_stall    = (r_state != S_IDLE) || !w_out_free;
    assign w_accept   = i_valid && !o_stall;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        if (i_message_bytes <= TIER_SMALL_MAX) begin
            w_tier = i_message_bytes;
        end else if (i_message_bytes <= TIER_MID_MAX) begin
            w_tier = TIER_MID_SIZE;
        end else if (i_message_bytes <= TIER_LARGE_MAX) begin
            w_tier = TIER_LARGE_SIZE;
        end else begin
            w_tier = TIER_HUGE_SIZE;
        end
    end

    // max wins over min; zero becomes one
    assign w_raised  = (r_size < r_min_frag) ? r_min_frag : r_size;
    assign w_capped  = (w_raised > r_max_frag) ? r_max_frag : w_raised;
    assign w_clamped = (w_capped == '0) ? LEN_W'(1) : w_capped;

    assign w_div_req.start    = (r_state == S_CLAMP);
    assign w_div_req.dividend = r_len;
    assign w_div_req.divisor  = w_clamped;

    assign w_count = w_div_rsp.quotient + LEN_W'(w_div_rsp.remainder != '0);

    assign w_rest  = r_len - r_offset;
    assign w_piece = (w_rest < r_size) ? w_rest : r_size;
    assign w_last  = ((r_index + LEN_W'(1)) == r_total);

    always_comb begin
        logic do_emit;
        do_emit     = 1'b0;
        n_state     = r_state;
        n_next_num  = r_next_num;
        n_act_num   = r_act_num;
        n_in_prog   = r_in_prog;
        n_index     = r_index;
        n_total     = r_total;
        n_len       = r_len;
        n_size      = r_size;
        n_offset    = r_offset;
        n_out_valid = r_out_valid && i_stall;
        n_hdr       = r_hdr;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (i_opcode)
                        OP_START_AUTO, OP_START_EXPL: begin
                            n_len      = i_message_bytes;
                            n_size     = (i_opcode == OP_START_AUTO) ? w_tier
                                                                     : i_requested_size;
                            n_act_num  = r_next_num;
                            n_next_num = r_next_num + NUM_W'(1);
                            n_in_prog  = 1'b0;
                            n_state    = S_CLAMP;
                        end
                        OP_CONTROL: begin
                            n_out_valid          = 1'b1;
                            n_hdr.message_number = r_next_num;
                            n_hdr.whole_length   = i_message_bytes;
                            n_hdr.piece_length   = i_message_bytes;
                            n_hdr.piece_index    = '0;
                            n_hdr.piece_count    = LEN_W'(1);
                            n_hdr.byte_offset    = '0;
                            n_hdr.final_piece    = 1'b1;
                            n_hdr.is_control     = 1'b1;
                            n_hdr.flag_byte      = i_control_bits;
                            n_next_num           = r_next_num + NUM_W'(1);
                        end
                        OP_NEXT: begin
                            do_emit = r_in_prog;
                        end
                        OP_ABORT: begin
                            n_in_prog = 1'b0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_CLAMP: begin
                n_size  = w_clamped;
                n_state = S_DIV;
            end
            S_DIV: begin
                if (w_div_rsp.done) begin
                    n_total  = w_count;
                    n_index  = '0;
                    n_offset = '0;
                    if (w_count == '0) begin
                        n_state = S_IDLE;
                    end else begin
                        n_in_prog = 1'b1;
                        n_state   = S_EMIT;
                    end
                end
            end
            S_EMIT: begin
                if (w_out_free) begin
                    do_emit = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (do_emit) begin
            n_out_valid          = 1'b1;
            n_hdr.message_number = r_act_num;
            n_hdr.whole_length   = r_len;
            n_hdr.piece_length   = w_piece;
            n_hdr.piece_index    = r_index;
            n_hdr.piece_count    = r_total;
            n_hdr.byte_offset    = r_offset;
            n_hdr.final_piece    = w_last;
            n_hdr.is_control     = 1'b0;
            n_hdr.flag_byte      = '0;
            if (w_last) begin
                n_in_prog = 1'b0;
            end else begin
                n_index  = r_index + LEN_W'(1);
                n_offset = r_offset + r_size;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_next_num  <= '0;
            r_act_num   <= '0;
            r_in_prog   <= 1'b0;
            r_index     <= '0;
            r_total     <= '0;
            r_len       <= '0;
            r_size      <= '0;
            r_offset    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_next_num  <= n_next_num;
            r_act_num   <= n_act_num;
            r_in_prog   <= n_in_prog;
            r_index     <= n_index;
            r_total     <= n_total;
            r_len       <= n_len;
            r_size      <= n_size;
            r_offset    <= n_offset;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hdr <= n_hdr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_frag <= MIN_FRAG_RESET;
            r_max_frag <= MAX_FRAG_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_MIN_FRAG: r_min_frag <= i_cfg_data;
                CFG_MAX_FRAG: r_max_frag <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_valid          = r_out_valid;
    assign o_message_number = r_hdr.message_number;
    assign o_whole_length   = r_hdr.whole_length;
    assign o_piece_length   = r_hdr.piece_length;
    assign o_piece_index    = r_hdr.piece_index;
    assign o_piece_count    = r_hdr.piece_count;
    assign o_byte_offset    = r_hdr.byte_offset;
    assign o_final_piece    = r_hdr.final_piece;
    assign o_is_control     = r_hdr.is_control;
    assign o_flag_byte      = r_hdr.flag_byte;

    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_rsp.done |-> (r_state == S_DIV))
        else $error("divider finished outside the divide state");

    a_index_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_prog |-> (r_index < r_total))
        else $error("fragment index past fragment count");

    a_offset_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_prog |-> (r_offset < r_len))
        else $error("fragment offset past message end");

    a_data_piece_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_is_control) |-> (o_piece_length != '0))
        else $error("empty data fragment");

endmodule

`default_nettype wire

// ----- test/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
    import mseg_pkg::*;

    localparam logic [OPCODE_W-1:0]  OP_RSVD_FIRST = 3'd5;
    localparam logic [OPCODE_W-1:0]  OP_RSVD_MID   = 3'd6;
    localparam logic [OPCODE_W-1:0]  OP_RSVD_LAST  = 3'd7;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED    = 2'd3;
    localparam int DRAIN_CYCLES = 60;
    localparam int HOLD_CYCLES  = 400;
    localparam int MAX_REPORTS  = 100;

    typedef struct {
        logic [OPCODE_W-1:0] op;
        logic [LEN_W-1:0]    len;
        logic [LEN_W-1:0]    req;
        logic [FLAG_W-1:0]   bits;
    } t_request;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_stall;
    logic [OPCODE_W-1:0]  i_opcode;
    logic [LEN_W-1:0]     i_message_bytes;
    logic [LEN_W-1:0]     i_requested_size;
    logic [FLAG_W-1:0]    i_control_bits;
    logic                 o_valid;
    logic                 i_stall;
    logic [NUM_W-1:0]     o_message_number;
    logic [LEN_W-1:0]     o_whole_length;
    logic [LEN_W-1:0]     o_piece_length;
    logic [LEN_W-1:0]     o_piece_index;
    logic [LEN_W-1:0]     o_piece_count;
    logic [LEN_W-1:0]     o_byte_offset;
    logic                 o_final_piece;
    logic                 o_is_control;
    logic [FLAG_W-1:0]    o_flag_byte;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [LEN_W-1:0]     i_cfg_data;

    message_segmentation_header_generator_core dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_opcode         (i_opcode),
        .i_message_bytes  (i_message_bytes),
        .i_requested_size (i_requested_size),
        .i_control_bits   (i_control_bits),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_message_number (o_message_number),
        .o_whole_length   (o_whole_length),
        .o_piece_length   (o_piece_length),
        .o_piece_index    (o_piece_index),
        .o_piece_count    (o_piece_count),
        .o_byte_offset    (o_byte_offset),
        .o_final_piece    (o_final_piece),
        .o_is_control     (o_is_control),
        .o_flag_byte      (o_flag_byte),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // segmenter state as predicted
    logic [LEN_W-1:0] lim_lo;
    logic [LEN_W-1:0] lim_hi;
    logic [NUM_W-1:0] num_next;
    logic [NUM_W-1:0] num_active;
    bit               busy;
    logic [LEN_W-1:0] frag_idx;
    logic [LEN_W-1:0] frag_cnt;
    logic [LEN_W-1:0] msg_len;
    logic [LEN_W-1:0] frag_sz;

    t_header expected_headers[$];

    int errors = 0;
    int words_sent = 0;
    int headers_checked = 0;
    int limit_settings = 1;
    int tx_idle_pct = 17;
    int rx_idle_pct = 17;
    int hold_left = 0;
    bit hold_go = 1'b0;

    function automatic logic [LEN_W-1:0] tier_of(input logic [LEN_W-1:0] len);
        if (len <= TIER_SMALL_MAX) return len;
        if (len <= TIER_MID_MAX) return TIER_MID_SIZE;
        if (len <= TIER_LARGE_MAX) return TIER_LARGE_SIZE;
        return TIER_HUGE_SIZE;
    endfunction

    // raise to min first, then lower to max; zero becomes one
    function automatic logic [LEN_W-1:0] fit_size(input logic [LEN_W-1:0] s);
        logic [LEN_W-1:0] v;
        v = s;
        if (v < lim_lo) v = lim_lo;
        if (v > lim_hi) v = lim_hi;
        if (v == '0) v = 32'd1;
        return v;
    endfunction

    task automatic emit_fragment();
        logic [63:0] off;
        logic [63:0] rest;
        logic [63:0] piece;
        t_header h;
        off = 64'(frag_idx) * 64'(frag_sz);
        rest = 64'(msg_len) - off;
        piece = (rest < 64'(frag_sz)) ? rest : 64'(frag_sz);
        h = '0;
        h.message_number = num_active;
        h.whole_length   = msg_len;
        h.piece_length   = piece[31:0];
        h.piece_index    = frag_idx;
        h.piece_count    = frag_cnt;
        h.byte_offset    = off[31:0];
        h.final_piece    = (64'(frag_idx) + 64'd1) == 64'(frag_cnt);
        if (h.final_piece) begin
            busy = 1'b0;
        end else begin
            frag_idx = frag_idx + 32'd1;
        end
        expected_headers.insert(expected_headers.size(), h);
    endtask

    task automatic begin_message(input logic [LEN_W-1:0] len, input logic [LEN_W-1:0] size);
        logic [63:0] cnt;
        frag_sz = fit_size(size);
        num_active = num_next;
        num_next = num_next + 64'd1;
        msg_len = len;
        cnt = (64'(len) + 64'(frag_sz) - 64'd1) / 64'(frag_sz);
        frag_cnt = cnt[31:0];
        frag_idx = '0;
        if (cnt == 64'd0) begin
            busy = 1'b0;
        end else begin
            busy = 1'b1;
            emit_fragment();
        end
    endtask

    task automatic model_word(input t_request w);
        t_header h;
        case (w.op)
            OP_START_AUTO: begin
                begin_message(w.len, tier_of(w.len));
            end
            OP_START_EXPL: begin
                begin_message(w.len, w.req);
            end
            OP_CONTROL: begin
                h = '0;
                h.message_number = num_next;
                num_next = num_next + 64'd1;
                h.whole_length = w.len;
                h.piece_length = w.len;
                h.piece_count  = 32'd1;
                h.final_piece  = 1'b1;
                h.is_control   = 1'b1;
                h.flag_byte    = w.bits;
                expected_headers.insert(expected_headers.size(), h);
            end
            OP_NEXT: begin
                if (busy) emit_fragment();
            end
            OP_ABORT: begin
                busy = 1'b0;
            end
            default: ;
        endcase
    endtask

    function automatic logic [LEN_W-1:0] rand_span();
        return $urandom() >> $urandom_range(0, 31);
    endfunction

    function automatic t_request rand_word();
        t_request w;
        w.op   = OPCODE_W'($urandom_range(0, 7));
        w.len  = rand_span();
        w.req  = rand_span();
        w.bits = FLAG_W'($urandom_range(0, 255));
        return w;
    endfunction

    task automatic send_word(input t_request w);
        int gap;
        bit counted;
        gap = 0;
        while ($urandom_range(0, 99) < tx_idle_pct && gap < 20) gap++;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid          <= 1'b1;
        i_opcode         <= w.op;
        i_message_bytes  <= w.len;
        i_requested_size <= w.req;
        i_control_bits   <= w.bits;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        counted = (w.op <= OP_CONTROL) || (busy && (w.op == OP_NEXT || w.op == OP_ABORT));
        model_word(w);
        if (counted) words_sent++;
    endtask

    task automatic send_op(input logic [OPCODE_W-1:0] op, input logic [LEN_W-1:0] len,
                           input logic [LEN_W-1:0] req, input logic [FLAG_W-1:0] bits);
        t_request w;
        w.op = op;
        w.len = len;
        w.req = req;
        w.bits = bits;
        send_word(w);
    endtask

    task automatic drain_and_wait();
        i_valid <= 1'b0;
        while (expected_headers.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [LEN_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx == CFG_MIN_FRAG) lim_lo = data;
        else if (idx == CFG_MAX_FRAG) lim_hi = data;
    endtask

    task automatic set_limits(input logic [LEN_W-1:0] lo, input logic [LEN_W-1:0] hi,
                              input bit poke_unused);
        drain_and_wait();
        if (poke_unused) cfg_write(CFG_UNUSED, $urandom());
        cfg_write(CFG_MIN_FRAG, lo);
        cfg_write(CFG_MAX_FRAG, hi);
        i_cfg_valid <= 1'b0;
        limit_settings++;
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t %s mismatch: expected %0h actual %0h", $time, name, want, got);
        end
    endtask

    task automatic compare_header(input t_header want, input t_header got);
        check_field("message_number", want.message_number, got.message_number);
        check_field("whole_length", 64'(want.whole_length), 64'(got.whole_length));
        check_field("piece_length", 64'(want.piece_length), 64'(got.piece_length));
        check_field("piece_index", 64'(want.piece_index), 64'(got.piece_index));
        check_field("piece_count", 64'(want.piece_count), 64'(got.piece_count));
        check_field("byte_offset", 64'(want.byte_offset), 64'(got.byte_offset));
        check_field("final_piece", 64'(want.final_piece), 64'(got.final_piece));
        check_field("is_control", 64'(want.is_control), 64'(got.is_control));
        check_field("flag_byte", 64'(want.flag_byte), 64'(got.flag_byte));
    endtask

    always @(posedge i_clk) begin : header_sink
        t_header got;
        t_header want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                got.message_number = o_message_number;
                got.whole_length   = o_whole_length;
                got.piece_length   = o_piece_length;
                got.piece_index    = o_piece_index;
                got.piece_count    = o_piece_count;
                got.byte_offset    = o_byte_offset;
                got.final_piece    = o_final_piece;
                got.is_control     = o_is_control;
                got.flag_byte      = o_flag_byte;
                if (expected_headers.size() == 0) begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("%0t unexpected header: expected none actual %0h",
                                 $time, got);
                end else begin
                    want = expected_headers.pop_front();
                    compare_header(want, got);
                    headers_checked++;
                end
            end
            if (hold_go) begin
                hold_left = HOLD_CYCLES;
                hold_go = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= ($urandom_range(0, 99) < rx_idle_pct);
            end
        end
    end

    task automatic test_idle_opcodes();
        send_op(OP_NEXT, '1, '1, '1);
        send_op(OP_ABORT, '0, '0, '0);
        send_op(OP_RSVD_FIRST, 32'd100, 32'd100, 8'h5a);
        send_op(OP_RSVD_MID, 32'd7, 32'd3, 8'ha5);
        send_op(OP_RSVD_LAST, '1, '0, '1);
    endtask

    task automatic test_control_and_tiers();
        send_op(OP_CONTROL, '0, '1, 8'hff);
        send_op(OP_CONTROL, '1, '0, 8'h00);
        send_op(OP_START_AUTO, '0, '1, '0);
        send_op(OP_START_AUTO, 32'd1, '0, '0);
        send_op(OP_START_AUTO, TIER_SMALL_MAX, '0, '0);
        send_op(OP_START_AUTO, TIER_SMALL_MAX + 32'd1, '0, '0);
        // control in the middle of a message, then a start that abandons it
        send_op(OP_START_AUTO, TIER_MID_MAX + 32'd1, '0, '0);
        send_op(OP_NEXT, '0, '0, '0);
        send_op(OP_CONTROL, 32'd55, '0, 8'h3c);
        send_op(OP_NEXT, '0, '0, '0);
        send_op(OP_START_EXPL, 32'd200, '0, '0);
        repeat (3) send_op(OP_NEXT, '0, '0, '0);
        send_op(OP_NEXT, '0, '0, '0);
        send_op(OP_START_AUTO, '1, '0, '0);
        send_op(OP_NEXT, '0, '0, '0);
        send_op(OP_ABORT, '0, '0, '0);
        send_op(OP_NEXT, '0, '0, '0);
        send_op(OP_START_EXPL, '1, '1, '0);
    endtask

    task automatic test_clamp_limits();
        set_limits(32'd1, '1, 1'b1);
        send_op(OP_START_EXPL, 32'd5, 32'd1, '0);
        repeat (4) send_op(OP_NEXT, '0, '0, '0);
        send_op(OP_START_EXPL, '1, '0, '0);
        send_op(OP_NEXT, '0, '0, '0);
        send_op(OP_ABORT, '0, '0, '0);
        // maximum wins over a larger minimum
        set_limits(32'd100, 32'd10, 1'b0);
        send_op(OP_START_EXPL, 32'd35, 32'd50, '0);
        repeat (3) send_op(OP_NEXT, '0, '0, '0);
        // zero size becomes one byte
        set_limits('0, '0, 1'b0);
        send_op(OP_START_EXPL, 32'd3, 32'd7, '0);
        repeat (2) send_op(OP_NEXT, '0, '0, '0);
        set_limits('1, '1, 1'b1);
        send_op(OP_START_AUTO, 32'd10, '0, '0);
        send_op(OP_START_EXPL, '1, '1, '0);
        set_limits(MIN_FRAG_RESET, MAX_FRAG_RESET, 1'b0);
    endtask

    task automatic random_messages(input int count);
        int base;
        int pulls;
        t_request w;
        logic [LEN_W-1:0] sz;
        logic [63:0] span;
        base = words_sent;
        while (words_sent - base < count) begin
            w = rand_word();
            if ($urandom_range(0, 99) < 10) begin
                case ($urandom_range(0, 3))
                    0: w.op = OP_NEXT;
                    1: w.op = OP_ABORT;
                    2: w.op = OP_CONTROL;
                    default: w.op = OPCODE_W'($urandom_range(OP_RSVD_FIRST, OP_RSVD_LAST));
                endcase
                send_word(w);
            end else begin
                if ($urandom_range(0, 1)) begin
                    w.op = OP_START_EXPL;
                    if ($urandom_range(0, 2) == 0) w.req = $urandom_range(0, 300);
                    sz = fit_size(w.req);
                    span = 64'(sz) * 64'($urandom_range(1, 6)) -
                           64'($urandom_range(0, sz - 32'd1));
                    if ($urandom_range(0, 29) == 0) w.len = '0;
                    else if ($urandom_range(0, 4) == 0 || span > 64'hffff_ffff)
                        w.len = rand_span();
                    else w.len = span[31:0];
                end else begin
                    w.op = OP_START_AUTO;
                    case ($urandom_range(0, 6))
                        0: w.len = $urandom_range(0, 1024);
                        1: w.len = $urandom_range(1025, 70000);
                        2: w.len = TIER_MID_MAX + $urandom_range(0, 1);
                        3: w.len = TIER_LARGE_MAX + $urandom_range(0, 1);
                        4: w.len = TIER_SMALL_MAX + $urandom_range(0, 1);
                        5: w.len = $urandom_range(1048577, 1200000);
                        default: ;
                    endcase
                end
                send_word(w);
                pulls = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4) : 16;
                while (busy && pulls > 0) begin
                    w = rand_word();
                    case ($urandom_range(0, 19))
                        0: w.op = OP_CONTROL;
                        1: w.op = OPCODE_W'($urandom_range(OP_RSVD_FIRST, OP_RSVD_LAST));
                        default: w.op = OP_NEXT;
                    endcase
                    send_word(w);
                    pulls--;
                end
                if (busy && $urandom_range(0, 9) < 6) begin
                    w = rand_word();
                    w.op = OP_ABORT;
                    send_word(w);
                end
            end
        end
    endtask

    task automatic test_random_traffic();
        random_messages(350);
        set_limits($urandom_range(1, 256), $urandom_range(256, 8192), 1'b0);
        random_messages(350);
        set_limits($urandom_range(0, 20), $urandom_range(0, 15), 1'b0);
        random_messages(350);
        // long stretch without idling on either side
        set_limits(32'd1, '1, 1'b1);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        random_messages(350);
        tx_idle_pct = 17;
        rx_idle_pct = 17;
        set_limits($urandom(), $urandom(), 1'b0);
        random_messages(350);
    endtask

    task automatic test_output_hold();
        int k;
        set_limits(MIN_FRAG_RESET, MAX_FRAG_RESET, 1'b0);
        tx_idle_pct = 0;
        hold_go = 1'b1;
        for (k = 0; k < 40; k++) begin
            if (k % 4 == 3) begin
                send_op(OP_START_EXPL, 32'd100, 32'd64, '0);
                send_op(OP_NEXT, '0, '0, '0);
            end else begin
                send_op(OP_CONTROL, $urandom(), $urandom(), FLAG_W'($urandom_range(0, 255)));
            end
        end
        tx_idle_pct = 17;
    endtask

    initial begin
        lim_lo = MIN_FRAG_RESET;
        lim_hi = MAX_FRAG_RESET;
        num_next = '0;
        num_active = '0;
        busy = 1'b0;
        frag_idx = '0;
        frag_cnt = '0;
        msg_len = '0;
        frag_sz = '0;
        i_rst_n          <= 1'b0;
        i_valid          <= 1'b0;
        i_opcode         <= OP_NEXT;
        i_message_bytes  <= '0;
        i_requested_size <= '0;
        i_control_bits   <= '0;
        i_cfg_valid      <= 1'b0;
        i_cfg_index      <= CFG_MIN_FRAG;
        i_cfg_data       <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_idle_opcodes();
        test_control_and_tiers();
        test_clamp_limits();
        test_random_traffic();
        test_output_hold();

        drain_and_wait();
        $display("covered %0d words in, %0d headers checked, %0d fragment size limit settings",
                 words_sent, headers_checked, limit_settings);
        $display("included tier edges, clamp order, zero size, aborts, control words, stalls");
        if (errors == 0) begin
            $display("PASS message_segmentation_header_generator_core");
        end else begin
            $display("FAIL message_segmentation_header_generator_core");
        end
        $finish;
    end

    initial begin
        #8000000;
        $display("timeout with %0d headers outstanding", expected_headers.size());
        $display("FAIL message_segmentation_header_generator_core");
        $finish;
    end

endmodule
